@@ hdl/knn_pkg.sv @@
// shared types and constants of the hamming knn classifier
package knn_pkg;

	localparam int ATTR_WIDTH = 4;
	localparam int NUM_ATTRS  = 4;
	localparam int CODES_W    = ATTR_WIDTH * NUM_ATTRS;
	localparam int DIST_W     = 3;
	localparam int INDEX_W    = 10;
	localparam int COUNT_W    = 11;
	localparam int MASK_W     = 4;
	localparam int CFG_DATA_W = 11;

	// stream layouts
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;
	localparam int M_USED_W  = 9;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// request kinds carried in s_tuser
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// configuration register indexes
	localparam logic REG_TRAIN_COUNT = 1'b0;
	localparam logic REG_ATTR_MASK   = 1'b1;

	localparam logic [MASK_W-1:0] ATTR_MASK_RESET = 4'hF;

	typedef struct packed {
		logic               is_query;
		logic [INDEX_W-1:0] index;
		logic [CODES_W-1:0] codes;
		logic               label;
	} cmd_t;

	typedef struct packed {
		logic               label;
		logic [CODES_W-1:0] codes;
	} rec_t;

endpackage

@@ hdl/knn_hamming_classifier.sv @@
// top level of the hamming distance knn classifier
//
// channel   dir  beat fields (lowest bit first)
// s_*       in   tuser: req_type; tdata: entry_index, attr_age, attr_degree,
//                attr_gender, attr_os, class_label
// m_*       out  tdata: predicted_class, positive_votes, neighbours_found
// wr_*      in   register write: 0 train_count, 1 attr_enable_mask
//
// a load beat costs one store write in the back end
// a query beat scans min(train_count, TRAIN_DEPTH) records through the single read
// port of the training store, one record per cycle
// reset is asynchronous; store contents are undefined until loaded
// the front keeps taking beats while the queue has room, and loads go on
// while a finished result waits in the output register
module knn_hamming_classifier #(
	parameter int TRAIN_DEPTH    = 1024,
	parameter int NUM_NEIGHBOURS = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// entry_index, attr_age, attr_degree, attr_gender, attr_os, class_label
	input  logic [knn_pkg::S_TDATA_W-1:0]  s_tdata,
	// req_type
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// predicted_class, positive_votes, neighbours_found
	output logic [knn_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                           wr_en,
	input  logic                           wr_index,
	input  logic [knn_pkg::CFG_DATA_W-1:0] wr_data
);
	import knn_pkg::*;

	// front to queue
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	// queue to back end
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// decode and range check of request beats
	knn_front #(
		.TRAIN_DEPTH(TRAIN_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	// lets the front run ahead while a scan is busy
	knn_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	// store, scan, neighbour list, vote
	knn_back #(
		.TRAIN_DEPTH   (TRAIN_DEPTH),
		.NUM_NEIGHBOURS(NUM_NEIGHBOURS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(pop_valid),
		.cmd_ready(pop_ready),
		.cmd      (pop_cmd),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ hdl/knn_front.sv @@
// front stage: takes request beats, decodes them, drops loads beyond the store
module knn_front #(
	parameter int TRAIN_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [knn_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tuser,
	output logic                          push_valid,
	input  logic                          push_ready,
	output knn_pkg::cmd_t                 push_cmd
);
	import knn_pkg::*;

	logic v_s1;
	logic keep_s1;
	cmd_t cmd_s1;
	cmd_t dec;
	logic dec_keep;

	always_comb begin
		dec.is_query = (s_tuser == REQ_QUERY);
		dec.index    = s_tdata[INDEX_W-1:0];
		dec.codes    = s_tdata[INDEX_W +: CODES_W];
		dec.label    = s_tdata[INDEX_W + CODES_W];
		// a load to a slot past the store is swallowed here
		dec_keep     = dec.is_query || (32'(dec.index) < TRAIN_DEPTH);
	end

	assign s_tready   = !v_s1 || !keep_s1 || push_ready;
	assign push_valid = v_s1 && keep_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			keep_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1    <= s_tvalid;
			keep_s1 <= dec_keep;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= dec;
		end
	end

endmodule

@@ hdl/knn_fifo.sv @@
// short command queue between front and back
module knn_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  knn_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output knn_pkg::cmd_t pop_cmd
);
	import knn_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ hdl/knn_back.sv @@
// back end: training store, scan, kept neighbour list, vote and result register
module knn_back #(
	parameter int TRAIN_DEPTH    = 1024,
	parameter int NUM_NEIGHBOURS = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  knn_pkg::cmd_t                  cmd,
	input  logic                           wr_en,
	input  logic                           wr_index,
	input  logic [knn_pkg::CFG_DATA_W-1:0] wr_data,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [knn_pkg::M_TDATA_W-1:0]  m_tdata
);
	import knn_pkg::*;

	localparam int AW = (TRAIN_DEPTH > 1) ? $clog2(TRAIN_DEPTH) : 1;
	localparam int CW = $clog2(TRAIN_DEPTH + 1);
	localparam int FW = $clog2(NUM_NEIGHBOURS + 1);
	localparam int K  = NUM_NEIGHBOURS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]         state_q;
	logic [COUNT_W-1:0] train_count_q;
	logic [MASK_W-1:0]  mask_q;

	rec_t               mem [TRAIN_DEPTH];
	rec_t               rd_data_s1;
	logic               rd_v_s1;

	logic [CODES_W-1:0] query_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      addr_q;
	logic [CW-1:0]      scan_len;
	logic               issue;
	logic               take;

	logic [DIST_W-1:0]  dist_q [K];
	logic               lab_q  [K];
	logic [FW-1:0]      filled_q;

	logic [DIST_W-1:0]  cand_dist;
	logic [K:0]         gt;
	logic [DIST_W-1:0]  dist_nx [K];
	logic               lab_nx  [K];

	logic [FW-1:0]      votes;
	logic               predicted;
	logic               out_free;

	assign cmd_ready = (state_q == ST_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign issue     = (state_q == ST_SCAN) && (addr_q < n_q);
	assign out_free  = !m_tvalid || m_tready;
	assign scan_len  = (32'(train_count_q) < TRAIN_DEPTH) ? CW'(train_count_q) : CW'(TRAIN_DEPTH);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			train_count_q <= '0;
			mask_q        <= ATTR_MASK_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_TRAIN_COUNT: train_count_q <= wr_data[COUNT_W-1:0];
				REG_ATTR_MASK:   mask_q        <= wr_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// training store, one port used at a time
	always_ff @(posedge clk) begin
		if (take && !cmd.is_query) begin
			mem[AW'(cmd.index)] <= '{label: cmd.label, codes: cmd.codes};
		end
		if (issue) begin
			rd_data_s1 <= mem[addr_q[AW-1:0]];
		end
	end

	// masked attribute mismatch count
	always_comb begin
		cand_dist = '0;
		for (int a = 0; a < NUM_ATTRS; a++) begin
			if (mask_q[a] &&
			    (rd_data_s1.codes[a*ATTR_WIDTH +: ATTR_WIDTH] !=
			     query_q[a*ATTR_WIDTH +: ATTR_WIDTH])) begin
				cand_dist = cand_dist + 1'b1;
			end
		end
	end

	// sorted insert: entries strictly farther move down one place
	always_comb begin
		gt[0] = 1'b0;
		for (int j = 0; j < K; j++) begin
			gt[j+1] = (FW'(j) < filled_q) && (dist_q[j] > cand_dist);
		end
		for (int j = 0; j < K; j++) begin
			dist_nx[j] = dist_q[j];
			lab_nx[j]  = lab_q[j];
			if (gt[j+1]) begin
				if (gt[j]) begin
					dist_nx[j] = dist_q[(j > 0) ? j - 1 : 0];
					lab_nx[j]  = lab_q[(j > 0) ? j - 1 : 0];
				end else begin
					dist_nx[j] = cand_dist;
					lab_nx[j]  = rd_data_s1.label;
				end
			end else if (FW'(j) == filled_q) begin
				// first free place takes the shifted tail or the candidate
				if (gt[j]) begin
					dist_nx[j] = dist_q[(j > 0) ? j - 1 : 0];
					lab_nx[j]  = lab_q[(j > 0) ? j - 1 : 0];
				end else begin
					dist_nx[j] = cand_dist;
					lab_nx[j]  = rd_data_s1.label;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			for (int j = 0; j < K; j++) begin
				dist_q[j] <= dist_nx[j];
				lab_q[j]  <= lab_nx[j];
			end
		end
		if (take && cmd.is_query) begin
			query_q <= cmd.codes;
			n_q     <= scan_len;
		end
	end

	// vote over the kept list
	always_comb begin
		votes = '0;
		for (int j = 0; j < K; j++) begin
			if (FW'(j) < filled_q) begin
				votes = votes + FW'(lab_q[j]);
			end
		end
		predicted = {votes, 1'b0} > {1'b0, filled_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			addr_q   <= '0;
			filled_q <= '0;
			rd_v_s1  <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			if (rd_v_s1 && (filled_q != FW'(K))) begin
				filled_q <= filled_q + 1'b1;
			end
			if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take && cmd.is_query) begin
						addr_q   <= '0;
						filled_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!issue && !rd_v_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata <= {(M_TDATA_W - M_USED_W)'(0), 4'(filled_q), 4'(votes), predicted};
		end
	end

endmodule

@@ hdl/knn_checker.sv @@
// port level checks of the classifier result stream, bound to the top level
module knn_checker #(
	parameter int NUM_NEIGHBOURS = 5
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [knn_pkg::M_TDATA_W-1:0] m_tdata
);
	import knn_pkg::*;

	logic       pred;
	logic [3:0] pos;
	logic [3:0] found;

	assign pred  = m_tdata[0];
	assign pos   = m_tdata[4:1];
	assign found = m_tdata[8:5];

	// stalled result beat stays up
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// stalled result beat keeps its data
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// never more neighbours than the list holds
	a_found_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(found) <= NUM_NEIGHBOURS))
		else $error("neighbour count above list size");

	// votes come from kept neighbours only
	a_votes_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pos <= found))
		else $error("positive votes exceed neighbours");

	// class follows the strict majority, tie gives zero
	a_majority: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pred == ({1'b0, pos, 1'b0} > {2'b00, found})))
		else $error("predicted class disagrees with the vote");

endmodule

bind knn_hamming_classifier knn_checker #(
	.NUM_NEIGHBOURS(NUM_NEIGHBOURS)
) u_knn_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

@@ test/testbench.sv @@
// self-checking stream testbench for the hamming distance knn classifier
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import knn_pkg::*;

	localparam int STORE_DEPTH     = 1024;
	localparam int KEEP            = 5;
	localparam int ITEMS_PER_PHASE = 24;
	localparam int PHASES_PER_MODE = 8;
	// loads are a single store write each in the back end and the front queue holds two beats
	localparam int SETTLE_CYCLES   = 16;
	// watchdog limit, well above the slowest correct run
	localparam int CYCLE_LIMIT     = 400000;

	// one classification result, holding the fields carried on m_tdata
	typedef struct packed {
		logic       winner;
		logic [3:0] votes;
		logic [3:0] found;
	} vote_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  wr_en    = 1'b0;
	logic                  wr_index = 1'b0;
	logic [CFG_DATA_W-1:0] wr_data  = '0;

	knn_hamming_classifier i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	// beats waiting to be driven, and verdicts waiting to come out
	cmd_t  request_queue [$];
	vote_t vote_queue [$];
	cmd_t  beat_on_bus;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int errors      = 0;
	int cycles      = 0;
	int loads_sent  = 0;
	int queries_sent = 0;
	int results_checked = 0;
	int settings_seen = 0;

	// predictor copy of the training store and registers
	logic [CODES_W-1:0] store_codes [STORE_DEPTH];
	logic               store_label [STORE_DEPTH];
	logic [COUNT_W-1:0] scan_count = '0;
	logic [MASK_W-1:0]  attr_mask  = ATTR_MASK_RESET;

	// stimulus side view of which slots hold a record
	bit                 slot_loaded [STORE_DEPTH];
	logic [3:0]         palette [NUM_ATTRS][2];

	// number of enabled attributes whose codes differ
	function automatic int attr_distance(logic [CODES_W-1:0] a, logic [CODES_W-1:0] b);
		int d;
		d = 0;
		for (int k = 0; k < NUM_ATTRS; k++) begin
			if (attr_mask[k] && a[k*ATTR_WIDTH +: ATTR_WIDTH] != b[k*ATTR_WIDTH +: ATTR_WIDTH])
				d++;
		end
		return d;
	endfunction

	// loads update the store; queries scan it and queue the vote they must give
	task automatic apply_request(cmd_t c);
		int    scan_n;
		int    kept_n;
		int    slot_pos;
		int    d;
		int    pos_votes;
		int    kept_dist [KEEP];
		logic  kept_label [KEEP];
		vote_t v;
		if (c.is_query == REQ_LOAD) begin
			store_codes[c.index] = c.codes;
			store_label[c.index] = c.label;
		end else begin
			scan_n = (scan_count > STORE_DEPTH) ? STORE_DEPTH : int'(scan_count);
			kept_n = 0;
			for (int i = 0; i < scan_n; i++) begin
				d = attr_distance(store_codes[i], c.codes);
				// a full list only takes a strictly nearer record, dropping its farthest
				if (kept_n == KEEP) begin
					if (d >= kept_dist[KEEP-1])
						continue;
					kept_n = KEEP - 1;
				end
				slot_pos = kept_n;
				while (slot_pos > 0 && kept_dist[slot_pos-1] > d)
					slot_pos--;
				for (int j = kept_n; j > slot_pos; j--) begin
					kept_dist[j]  = kept_dist[j-1];
					kept_label[j] = kept_label[j-1];
				end
				kept_dist[slot_pos]  = d;
				kept_label[slot_pos] = store_label[i];
				kept_n++;
			end
			pos_votes = 0;
			for (int i = 0; i < kept_n; i++)
				pos_votes += kept_label[i];
			// a tied vote goes to class 0
			v.winner = (pos_votes > kept_n - pos_votes);
			v.votes  = 4'(pos_votes);
			v.found  = 4'(kept_n);
			vote_queue.push_back(v);
		end
	endtask

	// driver: a beat counts at an edge with tvalid and tready high
	always @(posedge clk) begin
		logic took;
		took = s_tvalid && s_tready;
		if (took)
			apply_request(beat_on_bus);
		if (s_tvalid && !took) begin
			// hold the current beat until it is taken
		end else if (request_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
			beat_on_bus = request_queue.pop_front();
			s_tvalid <= 1'b1;
			s_tuser  <= beat_on_bus.is_query;
			s_tdata  <= {5'b0, beat_on_bus.label, beat_on_bus.codes, beat_on_bus.index};
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// monitor: compare every result beat with the oldest queued verdict
	always @(posedge clk) begin
		vote_t got;
		vote_t want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[0], m_tdata[4:1], m_tdata[8:5]};
			if (vote_queue.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, expected nothing actual %h",
					$time, m_tdata);
			end else begin
				want = vote_queue.pop_front();
				results_checked++;
				if (got.winner !== want.winner) begin
					errors++;
					$display("%0t: predicted_class expected %0d actual %0d",
						$time, want.winner, got.winner);
				end
				if (got.votes !== want.votes) begin
					errors++;
					$display("%0t: positive_votes expected %0d actual %0d",
						$time, want.votes, got.votes);
				end
				if (got.found !== want.found) begin
					errors++;
					$display("%0t: neighbours_found expected %0d actual %0d",
						$time, want.found, got.found);
				end
			end
		end
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// wait for the block to go quiet: nothing queued, nothing owed
	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_queue.size() != 0 || s_tvalid || vote_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_TRAIN_COUNT)
			scan_count = val;
		else
			attr_mask = val[MASK_W-1:0];
	endtask

	// registers only change with the block idle
	task automatic apply_setting(logic [COUNT_W-1:0] count, logic [MASK_W-1:0] mask);
		wait_drained();
		write_reg(REG_TRAIN_COUNT, count);
		write_reg(REG_ATTR_MASK, {{(CFG_DATA_W-MASK_W){1'b0}}, mask});
		settings_seen++;
	endtask

	task automatic push_load(int slot, logic [CODES_W-1:0] codes, logic label);
		cmd_t c;
		c.is_query = REQ_LOAD;
		c.index    = INDEX_W'(slot);
		c.codes    = codes;
		c.label    = label;
		request_queue.push_back(c);
		slot_loaded[slot] = 1'b1;
		loads_sent++;
	endtask

	// index and label of a query are don't-care fields, so they get noise
	task automatic push_query(logic [CODES_W-1:0] codes);
		cmd_t c;
		c.is_query = REQ_QUERY;
		c.index    = INDEX_W'($urandom_range(0, STORE_DEPTH - 1));
		c.codes    = codes;
		c.label    = 1'($urandom_range(0, 1));
		request_queue.push_back(c);
		queries_sent++;
	endtask

	// first slot never loaded; a query may only scan below it
	function automatic int loaded_prefix();
		for (int i = 0; i < STORE_DEPTH; i++)
			if (!slot_loaded[i])
				return i;
		return STORE_DEPTH;
	endfunction

	// two likely codes per attribute so distances spread over 0..4
	task automatic shuffle_palette();
		for (int a = 0; a < NUM_ATTRS; a++) begin
			palette[a][0] = 4'($urandom_range(0, 15));
			palette[a][1] = 4'($urandom_range(0, 15));
		end
	endtask

	function automatic logic [CODES_W-1:0] pick_codes();
		logic [CODES_W-1:0] w;
		for (int a = 0; a < NUM_ATTRS; a++) begin
			if ($urandom_range(0, 99) < 85)
				w[a*ATTR_WIDTH +: ATTR_WIDTH] = palette[a][$urandom_range(0, 1)];
			else
				w[a*ATTR_WIDTH +: ATTR_WIDTH] = 4'($urandom_range(0, 15));
		end
		return w;
	endfunction

	// a burst of loads and queries under one random register setting
	task automatic run_random_phase(bit pause_midway);
		int               pfx;
		int               cap;
		int               pick;
		logic [COUNT_W-1:0] count;
		logic [MASK_W-1:0]  mask;
		pfx  = loaded_prefix();
		cap  = (pfx < 40) ? pfx : 40;
		count = ($urandom_range(0, 9) == 0) ? '0 : COUNT_W'($urandom_range(1, cap));
		pick = $urandom_range(0, 7);
		if (pick < 3)
			mask = 4'hF;
		else if (pick == 3)
			mask = 4'h0;
		else
			mask = 4'($urandom_range(0, 15));
		apply_setting(count, mask);
		shuffle_palette();
		for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
			// sender holds off until every owed result is out
			if (pause_midway && i == ITEMS_PER_PHASE / 2)
				wait_drained();
			if ($urandom_range(0, 99) < 55) begin
				pfx = loaded_prefix();
				cap = (pfx + 2 > 63) ? 63 : pfx + 2;
				if ($urandom_range(0, 19) == 0)
					push_load($urandom_range(0, STORE_DEPTH - 1), pick_codes(),
						1'($urandom_range(0, 1)));
				else
					push_load($urandom_range(0, cap), pick_codes(), 1'($urandom_range(0, 1)));
			end else begin
				push_query(pick_codes());
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// sender idles less than the receiver
		tx_idle_pct = 23;
		rx_idle_pct = 48;

		// empty scan straight out of reset
		push_query(16'h0000);
		wait_drained();

		// hand-picked records: all ones, one attribute differs per record, a duplicate for ties
		push_load(0, 16'h0000, 1'b1);
		push_load(1, 16'hFFFF, 1'b0);
		push_load(2, 16'h000F, 1'b1);
		push_load(3, 16'h00F0, 1'b1);
		push_load(4, 16'h0F00, 1'b0);
		push_load(5, 16'hF000, 1'b1);
		push_load(6, 16'h0000, 1'b0);
		push_load(STORE_DEPTH - 1, 16'hA5C3, 1'b1);

		// full mask over seven records, list overflows and evicts
		apply_setting(11'd7, 4'hF);
		push_query(16'h0000);
		push_query(16'hFFFF);
		push_query(16'h5A5A);
		push_query(16'h0F0F);

		// all attributes masked off: every distance zero, the first five stay
		apply_setting(11'd7, 4'h0);
		push_query(16'h1234);

		// two records, one of each class: a tied vote
		apply_setting(11'd2, 4'h1);
		push_query(16'h0000);
		push_query(16'hFFFF);

		// a single attribute enabled, fewer records than neighbours
		apply_setting(11'd4, 4'h8);
		push_query(16'hF000);

		for (int p = 0; p < PHASES_PER_MODE; p++)
			run_random_phase(p == 3);

		// receiver idles less than the sender
		tx_idle_pct = 48;
		rx_idle_pct = 23;
		for (int p = 0; p < PHASES_PER_MODE; p++)
			run_random_phase(1'b0);

		// full speed on both sides
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int p = 0; p < PHASES_PER_MODE; p++)
			run_random_phase(1'b0);

		wait_drained();
		if (vote_queue.size() != 0) begin
			errors++;
			$display("%0t: %0d results expected but never seen, expected 0 actual %0d",
				$time, vote_queue.size(), vote_queue.size());
		end

		$display("run covered %0d loads and %0d queries across %0d register settings",
			loads_sent, queries_sent, settings_seen);
		$display("%0d result beats checked in %0d cycles", results_checked, cycles);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
